@@ rtl/u8d_pkg.sv @@
// Shared types, constants and byte classification for the UTF-8 decoder.
package u8d_pkg;

  // Lead byte class: bad lead/continuation, or announced sequence length
  typedef enum logic [2:0] {
    LEAD_BAD,
    LEAD_ONE,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR
  } lead_e;

  // One byte with its class
  typedef struct packed {
    logic [7:0] data;
    lead_e      lead;
  } ent_t;

  // One queued word from the front end
  typedef struct packed {
    ent_t ent;
    logic last;
  } item_t;

  localparam logic [7:0]  CONT_MASK    = 8'hc0;
  localparam logic [7:0]  CONT_PAT     = 8'h80;
  localparam logic [7:0]  LEAD_MAX_BAD = 8'hc1;
  localparam logic [7:0]  LEAD_MIN_BAD = 8'hf5;
  localparam logic [7:0]  LEAD_E0      = 8'he0;
  localparam logic [7:0]  LEAD_F0      = 8'hf0;
  localparam logic [7:0]  LEAD_F4      = 8'hf4;
  localparam logic [7:0]  MIN_E0_NEXT  = 8'ha0;
  localparam logic [7:0]  MIN_F0_NEXT  = 8'h90;
  localparam logic [7:0]  MAX_F4_NEXT  = 8'h90;
  localparam logic [20:0] PLANE1_BASE  = 21'h010000;
  localparam logic [15:0] SURR_HIGH    = 16'hd800;
  localparam logic [15:0] SURR_LOW     = 16'hdc00;

  function automatic lead_e lead_class(input logic [7:0] c);
    lead_e r;
    if (c < CONT_PAT) begin
      r = LEAD_ONE;
    end else if (c <= LEAD_MAX_BAD || c >= LEAD_MIN_BAD) begin
      r = LEAD_BAD;
    end else if (c < LEAD_E0) begin
      r = LEAD_TWO;
    end else if (c < LEAD_F0) begin
      r = LEAD_THREE;
    end else begin
      r = LEAD_FOUR;
    end
    return r;
  endfunction

  function automatic logic [2:0] lead_len(input lead_e l);
    logic [2:0] r;
    unique case (l)
      LEAD_ONE:   r = 3'd1;
      LEAD_TWO:   r = 3'd2;
      LEAD_THREE: r = 3'd3;
      LEAD_FOUR:  r = 3'd4;
      default:    r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/u8d_front.sv @@
// Front end: accepts bytes, classifies the lead, queues them for the back end.
module u8d_front import u8d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  input  logic       stream_last_i,
  output logic       q_valid_o,
  output item_t      q_item_o,
  input  logic       q_pop_i
);

  localparam int Depth = 2;

  item_t      mem_q [Depth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      new_item;

  assign in_stall_o = (cnt_q == 2'(Depth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];

  // classify on entry
  always_comb begin
    new_item.ent.data = byte_in_i;
    new_item.ent.lead = lead_class(byte_in_i);
    new_item.last     = stream_last_i;
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= new_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

@@ rtl/u8d_back.sv @@
// Back end: scans held plus new bytes and emits results; it pops a new byte only when idle.
module u8d_back import u8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        output_utf32_i,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_value_o,
  output logic        invalid_raw_o,
  output logic        run_end_o,
  output logic        string_end_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_LOW, ST_FLUSH} state_e;

  state_e      state_q, state_d;
  ent_t        buf_q [4];
  ent_t        buf_d [4];
  logic [2:0]  n_q, n_d, p_q, p_d;
  logic        last_q, last_d;
  logic [9:0]  low_q, low_d;
  ent_t        hb_q [3];
  ent_t        hb_d [3];
  logic [1:0]  hcnt_q, hcnt_d;
  logic        pend_v_q, pend_v_d, pend_bad_q, pend_bad_d;
  logic [20:0] pend_val_q, pend_val_d;
  logic        out_v_q, out_v_d, out_bad_q, out_bad_d;
  logic        out_re_q, out_re_d, out_se_q, out_se_d;
  logic [20:0] out_val_q, out_val_d;

  ent_t        w [4];
  logic [2:0]  avail, len, k;
  logic        ok;
  logic [20:0] t;
  logic [19:0] t_off;
  logic        out_free, can_emit;
  logic        emit;
  logic [20:0] emit_val;
  logic        emit_bad;
  logic [2:0]  idx;

  assign out_free = !out_v_q || !out_stall_i;
  assign can_emit = !pend_v_q || out_free;
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;

  // window of the buffer starting at the scan position
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      idx  = p_q + 3'(j);
      w[j] = (idx < n_q) ? buf_q[idx[1:0]] : '0;
    end
    avail = n_q - p_q;
    len   = lead_len(w[0].lead);
    k     = (avail < len) ? avail : len;
  end

  // prefix checks: continuation pattern, overlong, above range
  always_comb begin
    ok = 1'b1;
    for (int j = 1; j < 4; j++) begin
      if (3'(j) < k && (w[j].data & CONT_MASK) != CONT_PAT) ok = 1'b0;
    end
    if (k >= 3'd2) begin
      if (w[0].data == LEAD_E0 && w[1].data < MIN_E0_NEXT) ok = 1'b0;
      if (w[0].data == LEAD_F0 && w[1].data < MIN_F0_NEXT) ok = 1'b0;
      if (w[0].data == LEAD_F4 && w[1].data >= MAX_F4_NEXT) ok = 1'b0;
    end
  end

  // code point of a complete sequence
  always_comb begin
    unique case (len)
      3'd2:    t = {10'd0, w[0].data[4:0], w[1].data[5:0]};
      3'd3:    t = {5'd0, w[0].data[3:0], w[1].data[5:0], w[2].data[5:0]};
      default: t = {w[0].data[2:0], w[1].data[5:0], w[2].data[5:0], w[3].data[5:0]};
    endcase
    t_off = 20'(t - PLANE1_BASE);
  end

  // sequencer next state
  always_comb begin
    state_d    = state_q;
    buf_d      = buf_q;
    n_d        = n_q;
    p_d        = p_q;
    last_d     = last_q;
    low_d      = low_q;
    hb_d       = hb_q;
    hcnt_d     = hcnt_q;
    pend_v_d   = pend_v_q;
    pend_val_d = pend_val_q;
    pend_bad_d = pend_bad_q;
    out_v_d    = out_v_q && out_stall_i;
    out_val_d  = out_val_q;
    out_bad_d  = out_bad_q;
    out_re_d   = out_re_q;
    out_se_d   = out_se_q;
    emit       = 1'b0;
    emit_val   = '0;
    emit_bad   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          for (int j = 0; j < 4; j++) begin
            if (j < 3 && 2'(j) < hcnt_q) buf_d[j] = hb_q[j];
            else buf_d[j] = q_item_i.ent;
          end
          n_d     = 3'(hcnt_q) + 3'd1;
          p_d     = 3'd0;
          last_d  = q_item_i.last;
          hcnt_d  = 2'd0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (p_q >= n_q) begin
          state_d = ST_FLUSH;
        end else if (len <= 3'd1 || !ok || (k < len && last_q)) begin
          // single byte, bad lead or failed sequence: pass lead raw
          if (can_emit) begin
            emit     = 1'b1;
            emit_val = {13'd0, w[0].data};
            emit_bad = (len != 3'd1);
            p_d      = p_q + 3'd1;
          end
        end else if (k < len) begin
          // incomplete: hold the rest and finish the word
          for (int j = 0; j < 3; j++) begin
            if (3'(j) < k) hb_d[j] = w[j];
          end
          hcnt_d  = k[1:0];
          state_d = ST_FLUSH;
        end else if (can_emit) begin
          emit = 1'b1;
          p_d  = p_q + len;
          if (!output_utf32_i && t >= PLANE1_BASE) begin
            emit_val = {5'd0, SURR_HIGH | {6'd0, t_off[19:10]}};
            low_d    = t_off[9:0];
            state_d  = ST_LOW;
          end else begin
            emit_val = t;
          end
        end
      end
      ST_LOW: begin
        if (can_emit) begin
          emit     = 1'b1;
          emit_val = {5'd0, SURR_LOW | {6'd0, low_q}};
          state_d  = ST_SCAN;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_v_d   = 1'b1;
          out_val_d = pend_val_q;
          out_bad_d = pend_bad_q;
          out_re_d  = 1'b1;
          out_se_d  = last_q;
          pend_v_d  = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // a new result pushes the pending one out, not yet the last of its word
    if (emit) begin
      if (pend_v_q) begin
        out_v_d   = 1'b1;
        out_val_d = pend_val_q;
        out_bad_d = pend_bad_q;
        out_re_d  = 1'b0;
        out_se_d  = 1'b0;
      end
      pend_v_d   = 1'b1;
      pend_val_d = emit_val;
      pend_bad_d = emit_bad;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      hcnt_q   <= 2'd0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      hcnt_q   <= hcnt_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    n_q        <= n_d;
    p_q        <= p_d;
    last_q     <= last_d;
    low_q      <= low_d;
    hb_q       <= hb_d;
    pend_val_q <= pend_val_d;
    pend_bad_q <= pend_bad_d;
    out_val_q  <= out_val_d;
    out_bad_q  <= out_bad_d;
    out_re_q   <= out_re_d;
    out_se_q   <= out_se_d;
  end

  assign out_valid_o   = out_v_q;
  assign code_value_o  = out_val_q;
  assign invalid_raw_o = out_bad_q;
  assign run_end_o     = out_re_q;
  assign string_end_o  = out_se_q;

  // nothing may stay pending once a word is finished
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("pending result left when idle");

  // scan position never passes the buffer end
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (p_q <= n_q))
    else $error("scan position beyond buffer");

  // low surrogate always follows a pending high surrogate
  a_low_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOW) |-> pend_v_q)
    else $error("low surrogate without pending high");

  // held bytes always start with a multi-byte lead
  a_held_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && hcnt_q != 2'd0) |->
      (hb_q[0].lead == LEAD_TWO || hb_q[0].lead == LEAD_THREE ||
       hb_q[0].lead == LEAD_FOUR))
    else $error("held sequence without valid lead");

endmodule

@@ rtl/utf8_decoder_to_utf16_or_utf32.sv @@
// Top level of the UTF-8 to UTF-16 / UTF-32 stream decoder.
//
// Input channel: one UTF-8 byte per word (byte_in_i) with stream_last_i on
// the final byte of a string; taken when in_valid_i is high and in_stall_o
// is low. A two-entry queue sits behind the input port.
// Output channel: one code unit, code point or raw invalid byte per word,
// taken when out_valid_o is high and out_stall_i is low. run_end_o marks the
// last word caused by an input byte, string_end_o the last word of a string.
// Configuration: cfg_data_i is written to the output-format bit when
// cfg_valid_i is high (cfg_ready_o is always high); 1 selects UTF-32.
// The back end pops a byte, emits each result that it yields (extra results
// for a surrogate pair or replayed held bytes), ends the scan and closes the
// word before it pops the next byte. The scan sequencer sets the rate.
// Reset empties the queue and the held bytes and selects UTF-16 output.
// A stalled receiver holds the output register; the back end then stops at
// its next result and the input queue fills and stalls the sender.
module utf8_decoder_to_utf16_or_utf32 import u8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  input  logic        stream_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_value_o,
  output logic        invalid_raw_o,
  output logic        run_end_o,
  output logic        string_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  logic  output_utf32_q;
  logic  q_valid, q_pop;
  item_t q_item;

  assign cfg_ready_o = 1'b1;

  // output format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_utf32_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      output_utf32_q <= cfg_data_i;
    end
  end

  u8d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_in_i     (byte_in_i),
    .stream_last_i (stream_last_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  u8d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .output_utf32_i (output_utf32_q),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_value_o   (code_value_o),
    .invalid_raw_o  (invalid_raw_o),
    .run_end_o      (run_end_o),
    .string_end_o   (string_end_o)
  );

endmodule
